// File: hdl/tsig_pkg.sv
// package for the time-serial id generator
// fixed field widths, the base reset constant and controller command/status structs
package tsig_pkg;

   localparam int SEC_WIDTH  = 40;
   localparam int GUID_WIDTH = 63;

   localparam logic [SEC_WIDTH-1:0] BASE_RESET = 40'd1625097600;

   typedef struct packed {
      logic clear;
      logic capture;
      logic read;
      logic update;
      logic pack;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ctrl_status_type;

endpackage

// File: hdl/tsig_req_if.sv
// request channel interface: valid/ready plus group, source index and time
// depends on tsig_pkg for the time width
interface tsig_req_if #(
   parameter int GROUP_WIDTH = 10,
   parameter int INDEX_WIDTH = 10
);
   logic                           valid;
   logic                           ready;
   logic [GROUP_WIDTH-1:0]         group;
   logic [INDEX_WIDTH-1:0]         source_index;
   logic [tsig_pkg::SEC_WIDTH-1:0] now_seconds;

   modport source (output valid, output group, output source_index, output now_seconds,
                   input ready);
   modport sink (input valid, input group, input source_index, input now_seconds,
                 output ready);
endinterface

// File: hdl/tsig_rsp_if.sv
// response channel interface: valid/ready plus the packed identifier
// depends on tsig_pkg for the identifier width
interface tsig_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tsig_pkg::GUID_WIDTH-1:0] guid;

   modport source (output valid, output guid, input ready);
   modport sink (input valid, input guid, output ready);
endinterface

// File: hdl/tsig_ctrl.sv
// controller state machine: clearing pass, capture, counter read, update, pack
// depends on tsig_pkg for the command and status structs
module tsig_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tsig_pkg::ctrl_status_type  status,
   output tsig_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_PACK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PACK;
         end
         ST_PACK: begin
            if (status.out_free) begin
               cmd.pack = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/tsig_dp.sv
// datapath: serial counter memory, last second, base register, output register
// depends on tsig_pkg and tsig_rsp_if
module tsig_dp #(
   parameter int GROUP_WIDTH  = 10,
   parameter int INDEX_WIDTH  = 10,
   parameter int SERIAL_WIDTH = 13,
   parameter int STAMP_WIDTH  = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tsig_pkg::SEC_WIDTH-1:0] csr_wdata,
   input  logic [GROUP_WIDTH-1:0]         req_group,
   input  logic [INDEX_WIDTH-1:0]         req_source_index,
   input  logic [tsig_pkg::SEC_WIDTH-1:0] req_now_seconds,
   input  tsig_pkg::ctrl_cmd_type         cmd,
   output tsig_pkg::ctrl_status_type      status,
   tsig_rsp_if.source                     rsp
);

   localparam int DEPTH  = 1 << GROUP_WIDTH;
   localparam int PACK_W = STAMP_WIDTH + SERIAL_WIDTH + INDEX_WIDTH + GROUP_WIDTH;

   logic [SERIAL_WIDTH-1:0]          mem [DEPTH];
   logic [GROUP_WIDTH-1:0]           clear_addr_ff;
   logic [GROUP_WIDTH-1:0]           grp_ff;
   logic [INDEX_WIDTH-1:0]           idx_ff;
   logic [tsig_pkg::SEC_WIDTH-1:0]   now_ff;
   logic [SERIAL_WIDTH-1:0]          rd_ff;
   logic [tsig_pkg::SEC_WIDTH-1:0]   last_ff;
   logic [tsig_pkg::SEC_WIDTH-1:0]   last_in;
   logic [tsig_pkg::SEC_WIDTH-1:0]   base_ff;
   logic [SERIAL_WIDTH-1:0]          serial_ff;
   logic [SERIAL_WIDTH-1:0]          cnt_inc;
   logic [SERIAL_WIDTH-1:0]          cnt_in;
   logic                             later;
   logic                             cnt_wrap;
   logic [tsig_pkg::SEC_WIDTH-1:0]   diff;
   logic [PACK_W-1:0]                packed_w;
   logic [tsig_pkg::GUID_WIDTH-1:0]  guid_w;
   logic [tsig_pkg::GUID_WIDTH-1:0]  guid_ff;
   logic                             valid_ff;

   // counter update
   always_comb begin
      later    = now_ff > last_ff;
      cnt_inc  = rd_ff + 1'b1;
      cnt_wrap = &cnt_inc;
      cnt_in   = (later || cnt_wrap) ? '0 : cnt_inc;
      if (later) begin
         last_in = now_ff;
      end else if (cnt_wrap) begin
         last_in = now_ff + 1'b1;
      end else begin
         last_in = last_ff;
      end
   end

   // identifier packing
   assign diff     = last_ff - base_ff;
   assign packed_w = {diff[STAMP_WIDTH-1:0], serial_ff, idx_ff, grp_ff};

   generate
      if (PACK_W >= tsig_pkg::GUID_WIDTH) begin : g_trunc
         assign guid_w = packed_w[tsig_pkg::GUID_WIDTH-1:0];
      end else begin : g_ext
         assign guid_w = {{(tsig_pkg::GUID_WIDTH - PACK_W){1'b0}}, packed_w};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clear_addr_ff] <= '0;
      end else if (cmd.update) begin
         mem[grp_ff] <= cnt_in;
      end
      if (cmd.read) begin
         rd_ff <= mem[grp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         grp_ff <= req_group;
         idx_ff <= req_source_index;
         now_ff <= req_now_seconds;
      end
      if (cmd.update) begin
         serial_ff <= cnt_in;
      end
      if (cmd.pack) begin
         guid_ff <= guid_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         last_ff       <= '0;
         base_ff       <= tsig_pkg::BASE_RESET;
         valid_ff      <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (cmd.update) begin
            last_ff <= last_in;
         end
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         if (cmd.pack) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = &clear_addr_ff;
   assign status.out_free   = !valid_ff || rsp.ready;

   assign rsp.valid = valid_ff;
   assign rsp.guid  = guid_ff;

endmodule

// File: hdl/time_serial_id_generator_top.sv
// Time-serial id generator. Each request transaction (group, source index, time in
// seconds) yields one 63-bit identifier: stamp, per-group serial, index, group. The
// result register is loaded after acceptance via the read, update and pack states (counter
// memory read, counter update, stamp subtract and pack); the pack state waits for a free
// output register. The single-port counter memory and the controller sequence keep a new
// request out until the previous one is packed; the next request is taken as soon as the
// controller is back in idle, while the previous result may still wait on the response
// channel. After reset a clearing pass zeroes all 2^GROUP_WIDTH counter memory entries
// (1024 by default), during which no request is accepted; base_seconds writes on the csr
// port are taken at any time.
module time_serial_id_generator_top #(
   parameter int GROUP_WIDTH  = 10,
   parameter int INDEX_WIDTH  = 10,
   parameter int SERIAL_WIDTH = 13,
   parameter int STAMP_WIDTH  = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tsig_pkg::SEC_WIDTH-1:0] csr_wdata,
   tsig_req_if.sink                       req_if,
   tsig_rsp_if.source                     rsp_if
);

   tsig_pkg::ctrl_cmd_type    cmd;
   tsig_pkg::ctrl_status_type status;
   logic                      req_ready;

   assign req_if.ready = req_ready;

   tsig_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsig_dp #(
      .GROUP_WIDTH  (GROUP_WIDTH),
      .INDEX_WIDTH  (INDEX_WIDTH),
      .SERIAL_WIDTH (SERIAL_WIDTH),
      .STAMP_WIDTH  (STAMP_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_group        (req_if.group),
      .req_source_index (req_if.source_index),
      .req_now_seconds  (req_if.now_seconds),
      .cmd              (cmd),
      .status           (status),
      .rsp              (rsp_if)
   );

endmodule
